// ===== sv/mvrc_pkg.sv =====
`default_nettype none
package mvrc_pkg;

   localparam int LEAVES        = 1024;
   localparam int BLOCK_BYTES   = 4096;
   localparam int CACHE_ENTRIES = 64;

   localparam int NODES     = 2 * LEAVES - 1;
   localparam int WORDS_MAX = (BLOCK_BYTES + 3) / 4;
   localparam int NODE_W    = $clog2(NODES + 1);
   localparam int WCNT_W    = $clog2(WORDS_MAX + 1);
   localparam int CIDX_W    = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

   localparam logic [63:0] BLOCK_BITS = 64'(BLOCK_BYTES) * 64'd8;

   localparam logic [255:0] SHA_IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // final chunk of a block: end marker and message length
   localparam logic [511:0] PAD_CHUNK = {32'h80000000, 416'd0, BLOCK_BITS};
   // second chunk of a 64-byte node pair
   localparam logic [511:0] PAIR_PAD  = {32'h80000000, 448'd0, 32'd512};

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_RANGE = 3'd1,
      ST_LEAF  = 3'd2,
      ST_TREE  = 3'd3,
      ST_CACHE = 3'd4
   } status_type;

   typedef enum logic {
      CSR_BLOCK_COUNT  = 1'b0,
      CSR_CACHE_ENABLE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      SHA_IDLE,
      SHA_RUN,
      SHA_ADD
   } sha_state_type;

   typedef enum logic [3:0] {
      S_IN,
      S_CHUNK,
      S_COMP,
      S_PAD,
      S_LEAFW,
      S_W_RD,
      S_W_SIB,
      S_W_C1,
      S_W_C2S,
      S_W_C2,
      S_W_CHK,
      S_W_PUT,
      S_W_HIT,
      S_L_PUT,
      S_OUT
   } state_type;

   typedef struct packed {
      logic         start;
      logic [255:0] st;
      logic [511:0] blk;
   } sha_req_type;

   typedef struct packed {
      logic         done;
      logic [255:0] digest;
   } sha_rsp_type;

endpackage
`default_nettype wire

// ===== sv/mvrc_sha_core.sv =====
`default_nettype none
module mvrc_sha_core
   import mvrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire sha_req_type req,
   output sha_rsp_type      rsp
);

   sha_state_type state_ff, state_in;
   logic [5:0]  round_ff;
   logic [31:0] st_ff   [8];
   logic [31:0] work_ff [8];
   logic [31:0] w_ff    [16];
   logic [255:0] digest_ff;
   logic        done_ff;
   logic        run;
   logic        fin;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SHA_IDLE: if (req.start) state_in = SHA_RUN;
         SHA_RUN:  if (round_ff == 6'd63) state_in = SHA_ADD;
         SHA_ADD:  state_in = SHA_IDLE;
         default:  state_in = SHA_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      run = (state_ff == SHA_RUN);
      fin = (state_ff == SHA_ADD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SHA_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= fin;
      end
   end

   // one round per cycle, message schedule as a 16-word window
   always_ff @(posedge clock) begin
      logic [31:0] t1, t2, s0, s1, wn;
      t1 = work_ff[7] + (rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25))
         + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
         + SHA_K[round_ff] + w_ff[0];
      t2 = (rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22))
         + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^ (work_ff[1] & work_ff[2]));
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn = w_ff[0] + s0 + w_ff[9] + s1;
      if (state_ff == SHA_IDLE && req.start) begin
         for (int i = 0; i < 8; i++) begin
            st_ff[i]   <= req.st[255 - 32 * i -: 32];
            work_ff[i] <= req.st[255 - 32 * i -: 32];
         end
         for (int i = 0; i < 16; i++) w_ff[i] <= req.blk[511 - 32 * i -: 32];
         round_ff <= 6'd0;
      end else if (run) begin
         work_ff[7] <= work_ff[6];
         work_ff[6] <= work_ff[5];
         work_ff[5] <= work_ff[4];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[3] <= work_ff[2];
         work_ff[2] <= work_ff[1];
         work_ff[1] <= work_ff[0];
         work_ff[0] <= t1 + t2;
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= wn;
         round_ff <= round_ff + 6'd1;
      end
      // feed forward
      if (fin) begin
         for (int i = 0; i < 8; i++) digest_ff[255 - 32 * i -: 32] <= st_ff[i] + work_ff[i];
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.digest = digest_ff;

endmodule
`default_nettype wire

// ===== sv/merkle_verified_read_cache.sv =====
// Data word: accepted in S_IN; every 16th word adds a chunk compression.
// Block end: zero-fill at 1 word a cycle (pausing while a full chunk compresses) up to
// the block size, one padding chunk, then two compressions per tree level walked in the
// shared SHA-256 core. Load words: taken in S_IN. Result waits in an output register
// while loads proceed. Reset (synchronous): cache empty, LRU order by entry number,
// counters zero, registers to their defaults; the tree memory holds nothing until loaded.
`default_nettype none
module merkle_verified_read_cache
   import mvrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [10:0] req_node_index,
   input  wire logic [2:0]  req_word_select,
   input  wire logic [31:0] req_data_word,
   input  wire logic [9:0]  req_block_index,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_hashes_used,
   output logic [31:0]      rsp_reads_ok_total,
   output logic [31:0]      rsp_reads_failed_total,
   output logic [31:0]      rsp_hash_total,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [10:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [10:0]       block_count_ff;
   logic              cache_en_ff;
   logic [255:0]      chain_ff;
   logic [31:0]       buf_ff [16];
   logic [3:0]        fill_ff;
   logic [WCNT_W-1:0] wcnt_ff;
   logic              pad_ff;
   logic [NODE_W-1:0] leaf_idx_ff;
   logic [NODE_W-1:0] idx_ff;
   logic [255:0]      leaf_dig_ff;
   logic [255:0]      cur_ff;
   logic [255:0]      par_hash_ff;
   status_type        status_ff;
   logic [3:0]        used_ff;
   logic [31:0]       ok_cnt_ff, fail_cnt_ff, hash_cnt_ff;
   logic              rsp_valid_ff;
   logic [2:0]        rsp_status_ff;
   logic [3:0]        rsp_used_ff;
   logic [31:0]       rsp_ok_ff, rsp_fail_ff, rsp_hash_ff;

   // tree and cache stores
   logic [31:0]       tree_mem [NODES][8];
   logic [255:0]      tree_q;
   logic [255:0]      cval_mem [CACHE_ENTRIES];
   logic [255:0]      cval_q;
   logic [NODE_W-1:0] ctag_ff [CACHE_ENTRIES];
   logic              cvalid_ff [CACHE_ENTRIES];
   logic [CIDX_W-1:0] cage_ff [CACHE_ENTRIES];

   sha_req_type sha_req;
   sha_rsp_type sha_rsp;

   logic              req_fire, load_fire, data_fire;
   logic              feed, feed_full, out_of_range, out_fire;
   logic [31:0]       feed_word;
   logic [511:0]      chunk;
   logic [NODE_W-1:0] par_idx, sib_idx, leaf_addr, cam_tag;
   logic              tree_rd_en;
   logic [NODE_W-1:0] tree_rd_addr;
   logic [CACHE_ENTRIES-1:0] hit_vec, victim_vec;
   logic              hit_any;
   logic [CIDX_W-1:0] hit_idx, victim_idx, put_idx;
   logic [CIDX_W-1:0] touch_age;
   logic              touch_en, put_en, cval_rd_en;
   logic [255:0]      put_val;
   logic [31:0]       ok_next, fail_next, hash_next;

   mvrc_sha_core u_sha (
      .clock (clock),
      .reset (reset),
      .req   (sha_req),
      .rsp   (sha_rsp)
   );

   // handshake and decode
   assign req_fire     = req_valid && req_ready;
   assign load_fire    = req_fire && !req_kind;
   assign data_fire    = req_fire && req_kind;
   assign out_of_range = ({1'b0, req_block_index} >= block_count_ff)
                      || (32'(req_block_index) >= LEAVES);
   assign leaf_addr    = NODE_W'(LEAVES - 1) + NODE_W'(req_block_index);
   assign par_idx      = (idx_ff - NODE_W'(1)) >> 1;
   assign sib_idx      = idx_ff[0] ? idx_ff + NODE_W'(1) : idx_ff - NODE_W'(1);
   assign out_fire     = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   // word feed into the chunk buffer, zero words while padding
   always_comb begin
      feed      = 1'b0;
      feed_word = 32'd0;
      if (wcnt_ff < WCNT_W'(WORDS_MAX)) begin
         if (data_fire && !(req_last && out_of_range)) begin
            feed      = 1'b1;
            feed_word = req_data_word;
         end else if (state_ff == S_PAD) begin
            feed = 1'b1;
         end
      end
      feed_full = feed && (fill_ff == 4'd15);
      for (int i = 0; i < 16; i++) chunk[511 - 32 * i -: 32] = buf_ff[i];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IN: begin
            if (data_fire) begin
               if (req_last && out_of_range) state_in = S_OUT;
               else if (feed_full)           state_in = S_CHUNK;
               else if (req_last)            state_in = S_PAD;
            end
         end
         S_CHUNK: state_in = S_COMP;
         S_COMP:  if (sha_rsp.done) state_in = pad_ff ? S_PAD : S_IN;
         S_PAD: begin
            if (!feed)         state_in = S_LEAFW;
            else if (feed_full) state_in = S_CHUNK;
         end
         S_LEAFW: begin
            if (sha_rsp.done) begin
               if (sha_rsp.digest != tree_q) state_in = S_OUT;
               else if (cache_en_ff)         state_in = S_W_RD;
               else                          state_in = S_OUT;
            end
         end
         S_W_RD:  state_in = S_W_SIB;
         S_W_SIB: state_in = S_W_C1;
         S_W_C1:  if (sha_rsp.done) state_in = S_W_C2S;
         S_W_C2S: state_in = S_W_C2;
         S_W_C2:  if (sha_rsp.done) state_in = S_W_CHK;
         S_W_CHK: begin
            if (hit_any)                    state_in = S_W_HIT;
            else if (tree_q != par_hash_ff) state_in = S_OUT;
            else                            state_in = S_W_PUT;
         end
         S_W_PUT: state_in = (par_idx == NODE_W'(0)) ? S_L_PUT : S_W_RD;
         S_W_HIT: state_in = (cval_q != par_hash_ff) ? S_OUT : S_L_PUT;
         S_L_PUT: state_in = S_OUT;
         S_OUT:   if (out_fire) state_in = S_IN;
         default: state_in = S_IN;
      endcase
   end

   // outputs: core requests, memory reads, cache actions
   always_comb begin
      req_ready     = 1'b0;
      sha_req.start = 1'b0;
      sha_req.st    = chain_ff;
      sha_req.blk   = chunk;
      tree_rd_en    = 1'b0;
      tree_rd_addr  = sib_idx;
      touch_en      = 1'b0;
      put_en        = 1'b0;
      cval_rd_en    = 1'b0;
      put_val       = par_hash_ff;
      cam_tag       = par_idx;
      unique case (state_ff)
         S_IN:    req_ready = 1'b1;
         S_CHUNK: sha_req.start = 1'b1;
         S_PAD: begin
            if (!feed) begin
               sha_req.start = 1'b1;
               sha_req.blk   = PAD_CHUNK;
               tree_rd_en    = 1'b1;
               tree_rd_addr  = leaf_idx_ff;
            end
         end
         S_W_RD:  tree_rd_en = 1'b1;
         S_W_SIB: begin
            sha_req.start = 1'b1;
            sha_req.st    = SHA_IV;
            sha_req.blk   = idx_ff[0] ? {cur_ff, tree_q} : {tree_q, cur_ff};
            tree_rd_en    = 1'b1;
            tree_rd_addr  = par_idx;
         end
         S_W_C2S: begin
            sha_req.start = 1'b1;
            sha_req.st    = sha_rsp.digest;
            sha_req.blk   = PAIR_PAD;
         end
         S_W_CHK: begin
            touch_en   = hit_any;
            cval_rd_en = hit_any;
         end
         S_W_PUT: begin
            touch_en = 1'b1;
            put_en   = 1'b1;
         end
         S_L_PUT: begin
            touch_en = 1'b1;
            put_en   = 1'b1;
            put_val  = leaf_dig_ff;
            cam_tag  = leaf_idx_ff;
         end
         default: ;
      endcase
   end

   // tag match and LRU victim
   always_comb begin
      hit_idx    = '0;
      victim_idx = '0;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         hit_vec[i]    = cvalid_ff[i] && (ctag_ff[i] == cam_tag);
         victim_vec[i] = (cage_ff[i] == CIDX_W'(CACHE_ENTRIES - 1));
      end
      for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i])    hit_idx    = CIDX_W'(i);
         if (victim_vec[i]) victim_idx = CIDX_W'(i);
      end
      hit_any   = |hit_vec;
      put_idx   = hit_any ? hit_idx : victim_idx;
      touch_age = cage_ff[put_idx];
   end

   // running totals after this read
   always_comb begin
      ok_next   = ok_cnt_ff;
      fail_next = fail_cnt_ff;
      hash_next = hash_cnt_ff;
      if (status_ff != ST_RANGE) begin
         hash_next = hash_cnt_ff + 32'(used_ff);
         if (status_ff == ST_OK) ok_next   = ok_cnt_ff + 32'd1;
         else                    fail_next = fail_cnt_ff + 32'd1;
      end
   end

   // tree memory: word writes, full-node reads
   always_ff @(posedge clock) begin
      if (load_fire && (32'(req_node_index) < NODES))
         tree_mem[req_node_index[NODE_W-1:0]][req_word_select] <= req_data_word;
      if (tree_rd_en) begin
         for (int i = 0; i < 8; i++) tree_q[255 - 32 * i -: 32] <= tree_mem[tree_rd_addr][i];
      end
   end

   // cache value memory
   always_ff @(posedge clock) begin
      if (put_en) cval_mem[put_idx] <= put_val;
      if (cval_rd_en) cval_q <= cval_mem[hit_idx];
   end

   // cache tags, valid bits and ages
   always_ff @(posedge clock) begin
      if (put_en) ctag_ff[put_idx] <= cam_tag;
      if (reset) begin
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            cvalid_ff[i] <= 1'b0;
            cage_ff[i]   <= CIDX_W'(i);
         end
      end else begin
         if (put_en) cvalid_ff[put_idx] <= 1'b1;
         if (touch_en) begin
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
               if (CIDX_W'(i) == put_idx)    cage_ff[i] <= '0;
               else if (cage_ff[i] < touch_age) cage_ff[i] <= cage_ff[i] + CIDX_W'(1);
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IN;
         block_count_ff <= 11'd1024;
         cache_en_ff    <= 1'b1;
         chain_ff       <= SHA_IV;
         fill_ff        <= 4'd0;
         wcnt_ff        <= '0;
         pad_ff         <= 1'b0;
         ok_cnt_ff      <= 32'd0;
         fail_cnt_ff    <= 32'd0;
         hash_cnt_ff    <= 32'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_BLOCK_COUNT:  block_count_ff <= csr_wdata;
               CSR_CACHE_ENABLE: cache_en_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
         if (feed) begin
            fill_ff <= fill_ff + 4'd1;
            wcnt_ff <= wcnt_ff + WCNT_W'(1);
         end
         if (data_fire && req_last && !out_of_range) pad_ff <= 1'b1;
         if (state_ff == S_COMP && sha_rsp.done) chain_ff <= sha_rsp.digest;
         // clear the stream once the read is reported
         if (out_fire) begin
            chain_ff    <= SHA_IV;
            fill_ff     <= 4'd0;
            wcnt_ff     <= '0;
            pad_ff      <= 1'b0;
            ok_cnt_ff   <= ok_next;
            fail_cnt_ff <= fail_next;
            hash_cnt_ff <= hash_next;
         end
         if (out_fire)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (feed) begin
         for (int i = 0; i < 15; i++) buf_ff[i] <= buf_ff[i + 1];
         buf_ff[15] <= feed_word;
      end
      if (data_fire && req_last) begin
         leaf_idx_ff <= leaf_addr;
         status_ff   <= out_of_range ? ST_RANGE : ST_OK;
         used_ff     <= 4'd0;
      end
      if (state_ff == S_LEAFW && sha_rsp.done) begin
         used_ff     <= 4'd1;
         leaf_dig_ff <= sha_rsp.digest;
         cur_ff      <= sha_rsp.digest;
         idx_ff      <= leaf_idx_ff;
         if (sha_rsp.digest != tree_q) status_ff <= ST_LEAF;
      end
      if (state_ff == S_W_C2 && sha_rsp.done) begin
         par_hash_ff <= sha_rsp.digest;
         used_ff     <= used_ff + 4'd1;
      end
      if (state_ff == S_W_CHK && !hit_any && tree_q != par_hash_ff) status_ff <= ST_TREE;
      if (state_ff == S_W_HIT && cval_q != par_hash_ff) status_ff <= ST_CACHE;
      if (state_ff == S_W_PUT) begin
         cur_ff <= par_hash_ff;
         idx_ff <= par_idx;
      end
      if (out_fire) begin
         rsp_status_ff <= status_ff;
         rsp_used_ff   <= used_ff;
         rsp_ok_ff     <= ok_next;
         rsp_fail_ff   <= fail_next;
         rsp_hash_ff   <= hash_next;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_hashes_used        = rsp_used_ff;
   assign rsp_reads_ok_total     = rsp_ok_ff;
   assign rsp_reads_failed_total = rsp_fail_ff;
   assign rsp_hash_total         = rsp_hash_ff;

`ifndef NO_ASSERTIONS
   // ages stay a permutation: exactly one least recently used entry
   a_one_victim: assert property (@(posedge clock) disable iff (reset) $onehot(victim_vec))
      else $error("LRU ages lost their order");
   // a node is cached at most once
   a_unique_tag: assert property (@(posedge clock) disable iff (reset) $onehot0(hit_vec))
      else $error("node cached in two entries");
   // the padding chunk starts on a chunk boundary
   a_pad_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PAD && !feed) |-> (fill_ff == 4'd0))
      else $error("padding chunk not aligned");
   // the core finishes only while the sequencer waits for it
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      sha_rsp.done |-> (state_ff == S_COMP || state_ff == S_LEAFW
                        || state_ff == S_W_C1 || state_ff == S_W_C2))
      else $error("hash result arrived unexpectedly");
   // a rejected index spends no hash
   a_range_nohash: assert property (@(posedge clock) disable iff (reset)
      (out_fire && status_ff == ST_RANGE) |=> (rsp_hashes_used == 4'd0))
      else $error("hash counted on rejected index");
`endif

endmodule
`default_nettype wire
